/* rtl/ffha_pkg.sv */
// Package for the first-fit hole allocator.
// Holds default sizes, command, status and register codes, and the field write-enable type.
// No dependencies.
package ffha_pkg;

  localparam int DEF_HOLE_COUNT = 32;
  localparam int DEF_ADDR_BITS  = 20;

  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BEGIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_END   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_DESC   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

  // per-field write enables of a descriptor entry
  typedef struct packed {
    logic start;
    logic length;
    logic link;
  } fld_we_t;

endpackage

/* rtl/ffha_mem.sv */
// Descriptor table: start, length and link of every hole, one synchronous memory.
// One write port with per-field enables, one read port with registered data.
// Depends on ffha_pkg.
module ffha_mem #(
  parameter int HOLE_COUNT = ffha_pkg::DEF_HOLE_COUNT,
  parameter int ADDR_BITS  = ffha_pkg::DEF_ADDR_BITS,
  parameter int AW         = $clog2(HOLE_COUNT),
  parameter int IW         = $clog2(HOLE_COUNT + 1)
) (
  input  logic                 clk,
  input  ffha_pkg::fld_we_t    wr_we,
  input  logic [AW-1:0]        wr_idx,
  input  logic [ADDR_BITS-1:0] wr_start,
  input  logic [ADDR_BITS:0]   wr_len,
  input  logic [IW-1:0]        wr_link,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_idx,
  output logic [ADDR_BITS-1:0] rd_start,
  output logic [ADDR_BITS:0]   rd_len,
  output logic [IW-1:0]        rd_link
);
  import ffha_pkg::*;

  logic [ADDR_BITS-1:0] mem_start [HOLE_COUNT];
  logic [ADDR_BITS:0]   mem_len   [HOLE_COUNT];
  logic [IW-1:0]        mem_link  [HOLE_COUNT];

  always_ff @(posedge clk) begin
    if (wr_we.start) begin
      mem_start[wr_idx] <= wr_start;
    end
    if (wr_we.length) begin
      mem_len[wr_idx] <= wr_len;
    end
    if (wr_we.link) begin
      mem_link[wr_idx] <= wr_link;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_start <= mem_start[rd_idx];
      rd_len   <= mem_len[rd_idx];
      rd_link  <= mem_link[rd_idx];
    end
  end

endmodule

/* rtl/ffha_ctrl.sv */
// Command sequencer: list heads, break pointer, and the list walks over the descriptor table.
// Reads, modifies and writes back entries of ffha_mem.
// Depends on ffha_pkg.
module ffha_ctrl #(
  parameter int HOLE_COUNT = ffha_pkg::DEF_HOLE_COUNT,
  parameter int ADDR_BITS  = ffha_pkg::DEF_ADDR_BITS,
  parameter int AW         = $clog2(HOLE_COUNT),
  parameter int IW         = $clog2(HOLE_COUNT + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          command,
  input  logic [ADDR_BITS:0]            alloc_size,
  input  logic [ADDR_BITS-1:0]          free_address,
  input  logic                          bp_load,
  input  logic [ADDR_BITS-1:0]          heap_begin,
  input  logic [ADDR_BITS:0]            heap_end,
  output logic                          busy,
  output logic                          done,
  output logic [ADDR_BITS-1:0]          block_address,
  output logic [ffha_pkg::STATUS_W-1:0] status,
  output logic                          merged,
  output ffha_pkg::fld_we_t             wr_we,
  output logic [AW-1:0]                 wr_idx,
  output logic [ADDR_BITS-1:0]          wr_start,
  output logic [ADDR_BITS:0]            wr_len,
  output logic [IW-1:0]                 wr_link,
  output logic                          rd_en,
  output logic [AW-1:0]                 rd_idx,
  input  logic [ADDR_BITS-1:0]          rd_start,
  input  logic [ADDR_BITS:0]            rd_len,
  input  logic [IW-1:0]                 rd_link
);
  import ffha_pkg::*;

  localparam int SW = ADDR_BITS + 2;
  localparam logic [IW-1:0] NIL = IW'(HOLE_COUNT);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_AWALK, S_ACHK, S_POPS, S_PUSHU,
    S_FWALK, S_FCHK, S_FDEC, S_MWALK, S_MCHK, S_FSPARE
  } state_t;

  state_t               state;
  logic [AW-1:0]        clr;
  logic [IW-1:0]        cur, prev, steps, hit;
  logic [IW-1:0]        free_head, used_head, spare_head;
  logic [ADDR_BITS-1:0] bp, where, base, st;
  logic [ADDR_BITS:0]   size, ln;
  logic                 brk;

  logic [SW-1:0] sum_bp, limit;
  logic          brk_ok, walk_end, fit, exact, m_tail, m_head, to_bp;

  assign busy     = (state != S_IDLE);
  assign walk_end = (cur == NIL) || (steps == IW'(HOLE_COUNT));
  assign sum_bp   = SW'(bp) + SW'(size);
  assign limit    = (heap_end != '0) ? SW'(heap_end) : (SW'(1) << ADDR_BITS);
  assign brk_ok   = !(sum_bp > limit) && !(sum_bp > SW'({ADDR_BITS{1'b1}}));
  assign fit      = (rd_len >= size);
  assign exact    = (rd_len == size);
  assign m_tail   = (SW'(rd_start) + SW'(rd_len)) == SW'(st);
  assign m_head   = (SW'(st) + SW'(ln)) == SW'(rd_start);
  assign to_bp    = (SW'(st) + SW'(ln)) == SW'(bp);

  always_comb begin
    wr_we    = '0;
    wr_idx   = cur[AW-1:0];
    wr_start = '0;
    wr_len   = '0;
    wr_link  = NIL;
    rd_en    = 1'b0;
    rd_idx   = cur[AW-1:0];
    case (state)
      S_CLEAR: begin
        wr_we   = '{start: 1'b1, length: 1'b1, link: 1'b1};
        wr_idx  = clr;
        wr_link = (clr == '0) ? NIL : IW'(clr) - IW'(1);
      end
      S_AWALK, S_FWALK: begin
        if (!walk_end) begin
          rd_en = 1'b1;
        end else if (state == S_AWALK && brk_ok && spare_head != NIL) begin
          rd_en  = 1'b1;
          rd_idx = spare_head[AW-1:0];
        end
      end
      S_ACHK: begin
        if (fit && exact && prev != NIL) begin
          wr_we.link = 1'b1;
          wr_idx     = prev[AW-1:0];
          wr_link    = rd_link;
        end else if (fit && !exact && spare_head != NIL) begin
          // shrink the hole, fetch the spare descriptor for the given-out part
          wr_we.start  = 1'b1;
          wr_we.length = 1'b1;
          wr_start     = rd_start + size[ADDR_BITS-1:0];
          wr_len       = rd_len - size;
          rd_en        = 1'b1;
          rd_idx       = spare_head[AW-1:0];
        end
      end
      S_POPS: begin
        wr_we    = '{start: 1'b1, length: 1'b1, link: 1'b1};
        wr_idx   = spare_head[AW-1:0];
        wr_start = base;
        wr_len   = size;
        wr_link  = used_head;
      end
      S_PUSHU: begin
        wr_we.link = 1'b1;
        wr_idx     = hit[AW-1:0];
        wr_link    = used_head;
      end
      S_FCHK: begin
        if (rd_start == where && prev != NIL) begin
          wr_we.link = 1'b1;
          wr_idx     = prev[AW-1:0];
          wr_link    = rd_link;
        end
      end
      S_FDEC, S_FSPARE: begin
        if (state == S_FSPARE || to_bp) begin
          wr_we.link = 1'b1;
          wr_idx     = hit[AW-1:0];
          wr_link    = spare_head;
        end
      end
      S_MWALK: begin
        if (walk_end) begin
          wr_we.link = 1'b1;
          wr_idx     = hit[AW-1:0];
          wr_link    = free_head;
        end else begin
          rd_en = 1'b1;
        end
      end
      S_MCHK: begin
        if (m_tail) begin
          wr_we.length = 1'b1;
          wr_len       = rd_len + ln;
        end else if (m_head) begin
          wr_we.start  = 1'b1;
          wr_we.length = 1'b1;
          wr_start     = rd_start - ln[ADDR_BITS-1:0];
          wr_len       = rd_len + ln;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr           <= '0;
      free_head     <= NIL;
      used_head     <= NIL;
      spare_head    <= IW'(HOLE_COUNT - 1);
      bp            <= '0;
      done          <= 1'b0;
      block_address <= '0;
      status        <= ST_OK;
      merged        <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == AW'(HOLE_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            size  <= alloc_size;
            where <= free_address;
            prev  <= NIL;
            steps <= '0;
            if (command == CMD_FREE) begin
              cur   <= used_head;
              state <= S_FWALK;
            end else if (alloc_size == '0) begin
              done          <= 1'b1;
              block_address <= '0;
              status        <= ST_ZERO_SIZE;
              merged        <= 1'b0;
            end else begin
              cur   <= free_head;
              state <= S_AWALK;
            end
          end
        end
        S_AWALK: begin
          if (!walk_end) begin
            state <= S_ACHK;
          end else if (!brk_ok || spare_head == NIL) begin
            done          <= 1'b1;
            block_address <= '0;
            status        <= brk_ok ? ST_NO_DESC : ST_NO_SPACE;
            merged        <= 1'b0;
            state         <= S_IDLE;
          end else begin
            base  <= bp;
            brk   <= 1'b1;
            state <= S_POPS;
          end
        end
        S_ACHK: begin
          if (fit) begin
            base <= rd_start;
            hit  <= cur;
            brk  <= 1'b0;
            if (exact) begin
              if (prev == NIL) begin
                free_head <= rd_link;
              end
              state <= S_PUSHU;
            end else if (spare_head == NIL) begin
              done          <= 1'b1;
              block_address <= '0;
              status        <= ST_NO_DESC;
              merged        <= 1'b0;
              state         <= S_IDLE;
            end else begin
              state <= S_POPS;
            end
          end else begin
            prev  <= cur;
            cur   <= rd_link;
            steps <= steps + IW'(1);
            state <= S_AWALK;
          end
        end
        S_POPS: begin
          spare_head <= rd_link;
          used_head  <= spare_head;
          if (brk) begin
            bp <= bp + size[ADDR_BITS-1:0];
          end
          done          <= 1'b1;
          block_address <= base;
          status        <= ST_OK;
          merged        <= 1'b0;
          state         <= S_IDLE;
        end
        S_PUSHU: begin
          used_head     <= hit;
          done          <= 1'b1;
          block_address <= base;
          status        <= ST_OK;
          merged        <= 1'b0;
          state         <= S_IDLE;
        end
        S_FWALK: begin
          if (walk_end) begin
            done          <= 1'b1;
            block_address <= '0;
            status        <= ST_NOT_FOUND;
            merged        <= 1'b0;
            state         <= S_IDLE;
          end else begin
            state <= S_FCHK;
          end
        end
        S_FCHK: begin
          if (rd_start == where) begin
            hit <= cur;
            st  <= rd_start;
            ln  <= rd_len;
            if (prev == NIL) begin
              used_head <= rd_link;
            end
            state <= S_FDEC;
          end else begin
            prev  <= cur;
            cur   <= rd_link;
            steps <= steps + IW'(1);
            state <= S_FWALK;
          end
        end
        S_FDEC: begin
          if (to_bp) begin
            // block ends at the break: give it back
            bp            <= bp - ln[ADDR_BITS-1:0];
            spare_head    <= hit;
            done          <= 1'b1;
            block_address <= '0;
            status        <= ST_OK;
            merged        <= 1'b1;
            state         <= S_IDLE;
          end else begin
            cur   <= free_head;
            steps <= '0;
            state <= S_MWALK;
          end
        end
        S_MWALK: begin
          if (walk_end) begin
            free_head     <= hit;
            done          <= 1'b1;
            block_address <= '0;
            status        <= ST_OK;
            merged        <= 1'b0;
            state         <= S_IDLE;
          end else begin
            state <= S_MCHK;
          end
        end
        S_MCHK: begin
          if (m_tail || m_head) begin
            state <= S_FSPARE;
          end else begin
            cur   <= rd_link;
            steps <= steps + IW'(1);
            state <= S_MWALK;
          end
        end
        S_FSPARE: begin
          spare_head    <= hit;
          done          <= 1'b1;
          block_address <= '0;
          status        <= ST_OK;
          merged        <= 1'b1;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (bp_load) begin
        bp <= heap_begin;
      end
    end
  end

endmodule

/* rtl/first_fit_hole_allocator.sv */
// First-fit hole allocator, top level: configuration registers, sequencer and descriptor table.
// Allocate walks the free holes first fit, else moves the break; free walks the used entries,
// then gives the block back at the break, merges it into a free neighbor, or chains it as a hole.
// Zero size answers straight from idle; one transaction at a time. Reset (synchronous) runs a
// pass that chains all descriptors as spares with busy high.
// The one-cycle result strobe comes in the first idle cycle.
module first_fit_hole_allocator #(
  parameter int HOLE_COUNT = ffha_pkg::DEF_HOLE_COUNT,
  parameter int ADDR_BITS  = ffha_pkg::DEF_ADDR_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           command,
  input  logic [ADDR_BITS:0]             alloc_size,
  input  logic [ADDR_BITS-1:0]           free_address,
  output logic                           done,
  output logic [ADDR_BITS-1:0]           block_address,
  output logic [ffha_pkg::STATUS_W-1:0]  status,
  output logic                           merged,
  input  logic                           cfg_write,
  input  logic [ffha_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_BITS:0]             cfg_data
);
  import ffha_pkg::*;

  localparam int AW = $clog2(HOLE_COUNT);
  localparam int IW = $clog2(HOLE_COUNT + 1);

  logic [ADDR_BITS:0]   heap_end;
  logic                 bp_load;

  fld_we_t              wr_we;
  logic [AW-1:0]        wr_idx, rd_idx;
  logic [ADDR_BITS-1:0] wr_start, rd_start;
  logic [ADDR_BITS:0]   wr_len, rd_len;
  logic [IW-1:0]        wr_link, rd_link;
  logic                 rd_en;

  // heap begin only reloads the break, so it needs no register of its own
  assign bp_load = cfg_write && (cfg_index == REG_HEAP_BEGIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_end   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HEAP_END:   heap_end   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ffha_ctrl #(
    .HOLE_COUNT(HOLE_COUNT),
    .ADDR_BITS (ADDR_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .command      (command),
    .alloc_size   (alloc_size),
    .free_address (free_address),
    .bp_load      (bp_load),
    .heap_begin   (cfg_data[ADDR_BITS-1:0]),
    .heap_end     (heap_end),
    .busy         (busy),
    .done         (done),
    .block_address(block_address),
    .status       (status),
    .merged       (merged),
    .wr_we        (wr_we),
    .wr_idx       (wr_idx),
    .wr_start     (wr_start),
    .wr_len       (wr_len),
    .wr_link      (wr_link),
    .rd_en        (rd_en),
    .rd_idx       (rd_idx),
    .rd_start     (rd_start),
    .rd_len       (rd_len),
    .rd_link      (rd_link)
  );

  ffha_mem #(
    .HOLE_COUNT(HOLE_COUNT),
    .ADDR_BITS (ADDR_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_we   (wr_we),
    .wr_idx  (wr_idx),
    .wr_start(wr_start),
    .wr_len  (wr_len),
    .wr_link (wr_link),
    .rd_en   (rd_en),
    .rd_idx  (rd_idx),
    .rd_start(rd_start),
    .rd_len  (rd_len),
    .rd_link (rd_link)
  );

endmodule

/* rtl/ffha_checker.sv */
// Port-level checks for the first-fit hole allocator, bound onto the top level.
// Depends on ffha_pkg and first_fit_hole_allocator.
module ffha_checker #(
  parameter int ADDR_BITS = ffha_pkg::DEF_ADDR_BITS
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          busy,
  input logic                          done,
  input logic [ADDR_BITS-1:0]          block_address,
  input logic [ffha_pkg::STATUS_W-1:0] status,
  input logic                          merged
);
  import ffha_pkg::*;

  // a result always lands while the block is idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  a_rst_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_ZERO_SIZE || status == ST_NO_SPACE ||
              status == ST_NO_DESC || status == ST_NOT_FOUND))
    else $error("status code out of range");

  a_fail_addr: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> block_address == '0 && !merged)
    else $error("failed transaction carries an address or merge flag");

  a_merge_free: assert property (@(posedge clk) disable iff (rst)
    done && merged |-> block_address == '0)
    else $error("merged free transaction carries an address");

endmodule

bind first_fit_hole_allocator ffha_checker #(.ADDR_BITS(ADDR_BITS)) u_ffha_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .done         (done),
  .block_address(block_address),
  .status       (status),
  .merged       (merged)
);

/* test/first_fit_hole_allocator_test.sv */
// Self-checking testbench for first_fit_hole_allocator: directed and random allocate/free traffic.
// Carries its own model of the hole lists and break pointer; needs rtl/ffha_pkg.sv and the RTL.
module first_fit_hole_allocator_test;
  import ffha_pkg::*;

  localparam int HOLES = 32;
  localparam int AW = 20;
  localparam int NIL = HOLES;
  localparam longint unsigned ADDR_TOP = 64'd1 << AW;
  localparam int DRAIN_CYCLES = 4 * HOLES + 20;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [AW-1:0] addr;
    logic [STATUS_W-1:0] status;
    logic merged;
  } alloc_result_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic command;
  logic [AW:0] alloc_size;
  logic [AW-1:0] free_address;
  logic done;
  logic [AW-1:0] block_address;
  logic [STATUS_W-1:0] status;
  logic merged;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [AW:0] cfg_data;

  first_fit_hole_allocator u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .alloc_size(alloc_size), .free_address(free_address), .done(done),
    .block_address(block_address), .status(status), .merged(merged),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // mirror of the descriptor table and registers
  longint unsigned hole_base[HOLES];
  longint unsigned hole_len[HOLES];
  int hole_next[HOLES];
  int free_head, used_head, spare_head;
  longint unsigned brk, heap_lo, heap_hi;

  alloc_result_t expected_results[$];
  logic [AW-1:0] live_blocks[$];
  int mismatches = 0;
  int stall_cycles = 0;
  bit idle_enable = 1;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  task automatic model_reset();
    for (int i = 0; i < HOLES; i++) begin
      hole_base[i] = 0;
      hole_len[i] = 0;
      hole_next[i] = (i == 0) ? NIL : i - 1;
    end
    spare_head = HOLES - 1;
    free_head = NIL;
    used_head = NIL;
    heap_lo = 0;
    heap_hi = 0;
    brk = 0;
  endtask

  function automatic int take_spare();
    int s;
    s = spare_head;
    spare_head = hole_next[s];
    hole_next[s] = NIL;
    return s;
  endfunction

  task automatic model_alloc(input longint unsigned size, output alloc_result_t r);
    int prv, h, steps, s;
    longint unsigned base, limit;
    prv = NIL;
    h = free_head;
    steps = 0;
    r = '0;
    if (size == 0) begin
      r.status = ST_ZERO_SIZE;
      return;
    end
    while (h < NIL && steps < HOLES && hole_len[h] < size) begin
      prv = h;
      h = hole_next[h];
      steps++;
    end
    if (h < NIL && hole_len[h] >= size) begin
      base = hole_base[h];
      if (hole_len[h] == size) begin
        if (prv < NIL) hole_next[prv] = hole_next[h];
        else free_head = hole_next[h];
        hole_next[h] = used_head;
        used_head = h;
      end else begin
        if (spare_head >= NIL) begin
          r.status = ST_NO_DESC;
          return;
        end
        s = take_spare();
        hole_base[h] = (base + size) % ADDR_TOP;
        hole_len[h] = hole_len[h] - size;
        hole_base[s] = base;
        hole_len[s] = size;
        hole_next[s] = used_head;
        used_head = s;
      end
      r.addr = AW'(base);
      r.status = ST_OK;
      return;
    end
    limit = (heap_hi != 0) ? heap_hi : ADDR_TOP;
    if (brk + size > limit || brk + size > ADDR_TOP - 1) begin
      r.status = ST_NO_SPACE;
      return;
    end
    if (spare_head >= NIL) begin
      r.status = ST_NO_DESC;
      return;
    end
    h = take_spare();
    hole_base[h] = brk;
    hole_len[h] = size;
    hole_next[h] = used_head;
    used_head = h;
    r.addr = AW'(brk);
    r.status = ST_OK;
    brk = (brk + size) % ADDR_TOP;
  endtask

  task automatic model_free(input longint unsigned where, output alloc_result_t r);
    int prv, h, c, steps;
    longint unsigned st, ln;
    prv = NIL;
    h = used_head;
    steps = 0;
    r = '0;
    while (h < NIL && steps < HOLES && hole_base[h] != where) begin
      prv = h;
      h = hole_next[h];
      steps++;
    end
    if (h >= NIL || hole_base[h] != where) begin
      r.status = ST_NOT_FOUND;
      return;
    end
    if (prv < NIL) hole_next[prv] = hole_next[h];
    else used_head = hole_next[h];
    hole_next[h] = NIL;
    r.status = ST_OK;
    st = hole_base[h];
    ln = hole_len[h];
    if (st + ln == brk) begin
      brk = (brk - ln) % ADDR_TOP;
      hole_next[h] = spare_head;
      spare_head = h;
      r.merged = 1;
      return;
    end
    c = free_head;
    steps = 0;
    while (c < NIL && steps < HOLES) begin
      if (hole_base[c] + hole_len[c] == st) begin
        hole_len[c] = (hole_len[c] + ln) % (ADDR_TOP * 2);
        break;
      end
      if (st + ln == hole_base[c]) begin
        hole_base[c] = (hole_base[c] - ln) % ADDR_TOP;
        hole_len[c] = (hole_len[c] + ln) % (ADDR_TOP * 2);
        break;
      end
      c = hole_next[c];
      steps++;
    end
    if (c < NIL && steps < HOLES) begin
      hole_next[h] = spare_head;
      spare_head = h;
      r.merged = 1;
    end else begin
      hole_next[h] = free_head;
      free_head = h;
    end
  endtask

  task automatic predict(input logic cmd, input logic [AW:0] size, input logic [AW-1:0] addr);
    alloc_result_t r;
    if (cmd == CMD_ALLOC) begin
      model_alloc(size, r);
      if (r.status == ST_OK) live_blocks.push_back(r.addr);
    end else begin
      model_free(addr, r);
      if (r.status == ST_OK)
        foreach (live_blocks[i])
          if (live_blocks[i] == addr) begin
            live_blocks.delete(i);
            break;
          end
    end
    expected_results.push_back(r);
  endtask

  // one transaction; start stays high when the next one follows without a gap
  task automatic send(input logic cmd, input logic [AW:0] size, input logic [AW-1:0] addr);
    if (idle_enable && $urandom_range(99) < 22) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    alloc_size <= size;
    free_address <= addr;
    do @(posedge clk); while (busy);
    predict(cmd, size, addr);
  endtask

  task automatic send_alloc(input logic [AW:0] size);
    send(CMD_ALLOC, size, AW'($urandom));
  endtask

  task automatic send_free(input logic [AW-1:0] addr);
    send(CMD_FREE, (AW+1)'($urandom), addr);
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic write_heap(input logic [AW-1:0] lo, input logic [AW:0] hi);
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_HEAP_BEGIN;
    cfg_data <= {1'b0, lo};
    @(posedge clk);
    cfg_index <= REG_HEAP_END;
    cfg_data <= hi;
    @(posedge clk);
    cfg_write <= 1'b0;
    heap_lo = lo;
    brk = lo;
    heap_hi = hi;
  endtask

  task automatic free_all_live();
    while (live_blocks.size() != 0)
      send_free(live_blocks[$urandom_range(live_blocks.size() - 1)]);
  endtask

  task automatic test_basic_paths();
    logic [AW-1:0] a;
    send_alloc(0);
    send_alloc(21'h100000);
    send_alloc(21'h1FFFFF);
    send_free(20'hFFFFF);
    send_alloc(16);
    send_alloc(8);
    send_alloc(4);
    send_alloc(32);
    // free in the middle -> free hole; then exact fit and split of it
    send_free(20'd16);
    send_alloc(8);
    send_free(20'd24);
    send_free(20'd16);
    send_alloc(3);
    // a second free hole and a split of it; a free at the break, then frees of no live block
    send_free(20'd0);
    send_alloc(2);
    send_free(20'd28);
    send_free(20'd28);
    a = 20'd32;
    send_free(a);
    free_all_live();
  endtask

  task automatic test_descriptor_exhaustion();
    for (int i = 0; i < HOLES + 2; i++) send_alloc((AW+1)'($urandom_range(1, 4)));
    // make a free hole, then ask for a split with no spare left
    send_free(live_blocks[1]);
    send_alloc(1);
    send_alloc(1);
    send_alloc(100);
    free_all_live();
  endtask

  task automatic test_break_limits();
    write_heap(20'd1000, 21'd1040);
    send_alloc(40);
    send_alloc(1);
    send_alloc(41);
    free_all_live();
    write_heap(20'hFFFF0, 21'd0);
    send_alloc(15);
    send_alloc(1);
    send_alloc(16);
    free_all_live();
    write_heap(20'hFFFFF, 21'h100000);
    send_alloc(1);
    send_free(20'hFFFFF);
    write_heap(20'd0, 21'h100000);
  endtask

  task automatic test_random_traffic(input int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      idle_enable = !(n >= count / 3 && n < count / 3 + 80);
      if (n == count / 2) wait_all_results();
      pick = $urandom_range(99);
      if (pick < 4) send_alloc(0);
      else if (pick < 8) send_alloc((AW+1)'($urandom));
      else if (pick < 50) send_alloc((AW+1)'($urandom_range(1, 64)));
      else if (pick < 55) send_alloc((AW+1)'($urandom_range(1, 4096)));
      else if (pick < 92 && live_blocks.size() != 0)
        send_free(live_blocks[$urandom_range(live_blocks.size() - 1)]);
      else send_free(AW'($urandom));
    end
    idle_enable = 1;
  endtask

  // result checker
  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction");
      end else begin
        want = expected_results.pop_front();
        if (block_address !== want.addr || status !== want.status || merged !== want.merged) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp addr %h status %0d merged %0d, got %h %0d %0d",
                     want.addr, want.status, want.merged, block_address, status, merged);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done || cfg_write) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    command = CMD_ALLOC;
    alloc_size = '0;
    free_address = '0;
    cfg_write = 1'b0;
    cfg_index = REG_HEAP_BEGIN;
    cfg_data = '0;
    model_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_basic_paths();
    test_descriptor_exhaustion();
    test_break_limits();
    test_random_traffic(200);
    write_heap(20'd4096, 21'd0);
    test_random_traffic(150);
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
rtl/ffha_pkg.sv
rtl/ffha_mem.sv
rtl/ffha_ctrl.sv
rtl/first_fit_hole_allocator.sv
rtl/ffha_checker.sv
test/first_fit_hole_allocator_test.sv
